FILE: rtl/core/drct_pkg.sv
package drct_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int COMPLETION_RESERVE = 64;
    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CPL_DEPTH = RING_DEPTH + COMPLETION_RESERVE;
    localparam int CQ_W = $clog2(CPL_DEPTH + 1);
    localparam int PEND_W = 12;
    localparam logic [22:0] MAX_COPY = 23'd4194304;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_ENTRY = 2'd1;
    localparam logic [1:0] OP_POLL = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] KIND_TAIL = 2'd0;
    localparam logic [1:0] KIND_FULL = 2'd1;
    localparam logic [1:0] KIND_HEAD = 2'd2;
    localparam logic [1:0] KIND_REPORT = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [22:0] copy_length;
        logic [63:0] source_address;
        logic [63:0] destination_address;
        logic        entry_valid;
        logic [15:0] entry_ring_index;
        logic [15:0] entry_status;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [9:0]  slot_index;
        logic [10:0] doorbell_value;
        logic [9:0]  completed_count;
        logic        stopped_on_error;
        logic        batch_discarded;
        logic [22:0] descriptor_length;
        logic [63:0] descriptor_source;
        logic [63:0] descriptor_destination;
        logic        last;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan_start;
        logic scan_step;
        logic scan_done;
        logic emit_head;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_poll_commit;
        logic need_head;
        logic scan_more;
        logic clr_done;
    } dp_stat_t;

endpackage

FILE: rtl/core/drct_datapath.sv
module drct_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  drct_pkg::in_word_t  in_word,
    input  drct_pkg::dp_cmd_t   cmd,
    output drct_pkg::dp_stat_t  stat,
    output drct_pkg::out_word_t res_word,
    output logic                res_has
);

    localparam int IW = drct_pkg::IDX_W;
    localparam int CW = drct_pkg::CQ_W;

    logic [15:0] status_mem [drct_pkg::RING_DEPTH];
    logic [15:0] rd_reg;

    drct_pkg::in_word_t item_reg;
    logic [IW-1:0] sub_head_reg, sub_tail_reg, last_idx_reg, rep_head_reg;
    logic [10:0] cmp_head_reg, batch_head_reg;
    logic exp_phase_reg, batch_phase_reg, closed_reg, bad_reg;
    logic [CW-1:0] batch_cnt_reg;
    logic [drct_pkg::PEND_W-1:0] pend_reg;
    logic [63:0] total_reg;
    logic [31:0] full_reg;
    logic [IW-1:0] clr_idx_reg;
    logic clr_done_reg;
    logic [IW-1:0] scan_ptr_reg, scan_start_reg;
    logic [IW:0] scan_cnt_reg, scan_len_reg;
    logic need_head_reg;

    logic [IW-1:0] tail_inc, idx_lo;
    logic [10:0] head_inc;
    logic [22:0] len_sat;
    logic [IW-1:0] mem_addr;
    logic mem_we;
    logic [15:0] mem_wd;
    logic entry_ok;
    logic [drct_pkg::PEND_W-1:0] pend_sum;
    logic [IW-1:0] new_rep;

    assign tail_inc = sub_tail_reg + 1'b1;
    assign idx_lo = item_reg.entry_ring_index[IW-1:0];
    assign head_inc = cmp_head_reg + 1'b1;
    assign len_sat = (item_reg.copy_length > drct_pkg::MAX_COPY) ? drct_pkg::MAX_COPY
                                                                 : item_reg.copy_length;
    assign entry_ok = !closed_reg && (item_reg.entry_valid == exp_phase_reg)
                      && (item_reg.entry_ring_index[15:IW] == '0);
    assign pend_sum = pend_reg + drct_pkg::PEND_W'(batch_cnt_reg);
    assign new_rep = last_idx_reg + 1'b1;

    always_comb begin
        mem_we = 1'b0;
        mem_addr = scan_ptr_reg;
        mem_wd = '0;
        if (!clr_done_reg) begin
            mem_we = 1'b1;
            mem_addr = clr_idx_reg;
        end else if (cmd.exec && item_reg.op == drct_pkg::OP_ENTRY && entry_ok
                     && item_reg.entry_status != '0) begin
            mem_we = 1'b1;
            mem_addr = idx_lo;
            mem_wd = item_reg.entry_status;
        end else if (cmd.scan_start) begin
            mem_addr = sub_head_reg;
        end else if (cmd.scan_step) begin
            mem_addr = scan_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            status_mem[mem_addr] <= mem_wd;
        end
        rd_reg <= status_mem[mem_addr];
    end

    assign stat.is_poll_commit = (item_reg.op == drct_pkg::OP_POLL) && !bad_reg
                                 && (batch_cnt_reg != '0);
    assign stat.need_head = need_head_reg;
    assign stat.scan_more = (scan_cnt_reg < scan_len_reg) && (rd_reg == '0);
    assign stat.clr_done = clr_done_reg;

    always_comb begin
        res_word = '0;
        res_has = 1'b0;
        if (cmd.exec && item_reg.op == drct_pkg::OP_SUBMIT) begin
            res_has = 1'b1;
            res_word.slot_index = 10'(sub_tail_reg);
            res_word.last = 1'b1;
            if (tail_inc == sub_head_reg) begin
                res_word.result_kind = drct_pkg::KIND_FULL;
            end else begin
                res_word.result_kind = drct_pkg::KIND_TAIL;
                res_word.doorbell_value = 11'(tail_inc);
                res_word.descriptor_length = len_sat;
                res_word.descriptor_source = item_reg.source_address;
                res_word.descriptor_destination = item_reg.destination_address;
            end
        end else if (cmd.exec && item_reg.op == drct_pkg::OP_POLL
                     && (bad_reg || batch_cnt_reg == '0)) begin
            res_has = 1'b1;
            res_word.result_kind = drct_pkg::KIND_REPORT;
            res_word.slot_index = 10'(sub_head_reg);
            res_word.batch_discarded = bad_reg;
            res_word.last = 1'b1;
        end else if (cmd.emit_head) begin
            res_has = 1'b1;
            res_word.result_kind = drct_pkg::KIND_HEAD;
            res_word.doorbell_value = cmp_head_reg;
        end else if (cmd.scan_done) begin
            res_has = 1'b1;
            res_word.result_kind = drct_pkg::KIND_REPORT;
            res_word.slot_index = 10'(scan_start_reg);
            res_word.completed_count = 10'(scan_cnt_reg);
            res_word.stopped_on_error = scan_cnt_reg < scan_len_reg;
            res_word.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_word;
        end
        if (!aresetn) begin
            sub_head_reg <= '0;
            sub_tail_reg <= '0;
            cmp_head_reg <= '0;
            exp_phase_reg <= 1'b1;
            batch_head_reg <= '0;
            batch_phase_reg <= 1'b1;
            batch_cnt_reg <= '0;
            closed_reg <= 1'b0;
            bad_reg <= 1'b0;
            last_idx_reg <= '0;
            rep_head_reg <= '0;
            pend_reg <= '0;
            total_reg <= '0;
            full_reg <= '0;
            clr_idx_reg <= '0;
            clr_done_reg <= 1'b0;
            need_head_reg <= 1'b0;
            scan_cnt_reg <= '0;
            scan_len_reg <= '0;
            scan_ptr_reg <= '0;
            scan_start_reg <= '0;
        end else begin
            if (!clr_done_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == IW'(drct_pkg::RING_DEPTH - 1)) begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (cmd.exec) begin
                unique case (item_reg.op)
                    drct_pkg::OP_SUBMIT: begin
                        if (tail_inc == sub_head_reg) begin
                            full_reg <= full_reg + 1'b1;
                        end else begin
                            sub_tail_reg <= tail_inc;
                        end
                    end
                    drct_pkg::OP_ENTRY: begin
                        if (!closed_reg) begin
                            if (item_reg.entry_valid != exp_phase_reg) begin
                                closed_reg <= 1'b1;
                            end else if (item_reg.entry_ring_index[15:IW] != '0) begin
                                bad_reg <= 1'b1;
                                closed_reg <= 1'b1;
                            end else begin
                                last_idx_reg <= idx_lo;
                                batch_cnt_reg <= batch_cnt_reg + 1'b1;
                                if (head_inc >= 11'(drct_pkg::CPL_DEPTH)) begin
                                    cmp_head_reg <= '0;
                                    exp_phase_reg <= !exp_phase_reg;
                                end else begin
                                    cmp_head_reg <= head_inc;
                                end
                                if (batch_cnt_reg + 1'b1 >= CW'(drct_pkg::CPL_DEPTH)) begin
                                    closed_reg <= 1'b1;
                                end
                            end
                        end
                    end
                    drct_pkg::OP_POLL: begin
                        if (bad_reg || batch_cnt_reg == '0) begin
                            need_head_reg <= 1'b0;
                            if (bad_reg) begin
                                cmp_head_reg <= batch_head_reg;
                                exp_phase_reg <= batch_phase_reg;
                            end
                        end else begin
                            batch_head_reg <= cmp_head_reg;
                            batch_phase_reg <= exp_phase_reg;
                            rep_head_reg <= new_rep;
                            if (pend_sum >= drct_pkg::PEND_W'(drct_pkg::COMPLETION_RESERVE)) begin
                                need_head_reg <= 1'b1;
                                pend_reg <= '0;
                            end else begin
                                need_head_reg <= 1'b0;
                                pend_reg <= pend_sum;
                            end
                        end
                        batch_cnt_reg <= '0;
                        closed_reg <= 1'b0;
                        bad_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.scan_start) begin
                scan_ptr_reg <= sub_head_reg;
                scan_start_reg <= sub_head_reg;
                scan_cnt_reg <= '0;
                // equal heads scan nothing, else wrap distance
                if (rep_head_reg == sub_head_reg) begin
                    scan_len_reg <= '0;
                end else begin
                    scan_len_reg <= {1'b0, rep_head_reg - sub_head_reg};
                end
            end
            if (cmd.scan_step) begin
                scan_ptr_reg <= scan_ptr_reg + 1'b1;
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (cmd.scan_done) begin
                sub_head_reg <= scan_ptr_reg;
                total_reg <= total_reg + 64'(scan_cnt_reg);
            end
        end
    end

endmodule

FILE: rtl/core/drct_ctrl.sv
module drct_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               res_busy,
    input  drct_pkg::dp_stat_t stat,
    output drct_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_HEAD,
        ST_SCAN0,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE) && !res_busy;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                state_next = stat.is_poll_commit ? ST_HEAD : ST_IDLE;
            end
            ST_HEAD: begin
                if (!res_busy) begin
                    cmd.emit_head = stat.need_head;
                    cmd.scan_start = 1'b1;
                    state_next = ST_SCAN0;
                end
            end
            ST_SCAN0: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (stat.scan_more) begin
                    cmd.scan_step = 1'b1;
                    state_next = ST_SCAN0;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!res_busy) begin
                    cmd.scan_done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/dma_ring_completion_tracker_core.sv
// submit and plain poll: result registered from the exec state after accept; an entry gives no result
// a new word is accepted only in idle, once the last is done and the result side does not stall
// committed poll: exec, head, then scan0 and scan per completed slot, then done issues the report
// a head doorbell, when due, is issued from the head state, ahead of the report
// aresetn synchronous active low; after reset the status memory is cleared
// one slot per cycle; no word is accepted until the clear is done
module dma_ring_completion_tracker_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  drct_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output drct_pkg::out_word_t m_data
);

    drct_pkg::dp_cmd_t   cmd;
    drct_pkg::dp_stat_t  stat;
    drct_pkg::out_word_t res_word;
    logic                res_has;
    logic                res_busy;

    // single output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (res_has) begin
            m_valid <= 1'b1;
            m_data <= res_word;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    assign res_busy = m_valid && !m_ready;

    drct_ctrl u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .res_busy(res_busy),
        .stat(stat),
        .cmd(cmd)
    );

    drct_datapath u_dp (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_word(s_data),
        .cmd(cmd),
        .stat(stat),
        .res_word(res_word),
        .res_has(res_has)
    );

endmodule

FILE: rtl/core/drct_checker.sv
module drct_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input drct_pkg::out_word_t m_data
);

    a_mstable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_noready_rst: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready right after reset");

    a_full_nodesc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == drct_pkg::KIND_FULL |->
        m_data.descriptor_length == '0 && m_data.last)
        else $error("ring full result carries descriptor");

    a_head_notlast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == drct_pkg::KIND_HEAD |-> !m_data.last)
        else $error("head doorbell flagged last");

endmodule

bind dma_ring_completion_tracker_core drct_checker u_chk (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data(m_data)
);
